// ===== hdl/psched_pkg.sv =====
package psched_pkg;

    localparam int NUM_SOURCES = 2;
    localparam int SRC_W       = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int TICK_W      = 32;
    localparam int CNT_W       = 16;

    localparam logic [SRC_W-1:0] NO_SOURCE = 2'd2;
    localparam logic [CNT_W-1:0] SAT16     = 16'hFFFF;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIORITY_A = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIORITY_B = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_TIME_A = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_TIME_B = 8'd3;

    localparam logic [7:0]  PRIORITY_A_RST = 8'd1;
    localparam logic [7:0]  PRIORITY_B_RST = 8'd2;
    localparam logic [15:0] RUN_TIME_A_RST = 16'd1;
    localparam logic [15:0] RUN_TIME_B_RST = 16'd1;

    typedef struct packed {
        logic [7:0]  priority_a;
        logic [7:0]  priority_b;
        logic [15:0] run_time_a;
        logic [15:0] run_time_b;
    } cfg_t;

    typedef struct packed {
        logic [SRC_W-1:0]       active_source;
        logic                   finished_valid;
        logic                   finished_source;
        logic [CNT_W-1:0]       finish_latency;
        logic [NUM_SOURCES-1:0] pending_bits;
        logic [CNT_W-1:0]       missed_count_a;
        logic [CNT_W-1:0]       missed_count_b;
        logic [CNT_W-1:0]       max_latency_a;
        logic [CNT_W-1:0]       max_latency_b;
    } result_t;

    // Highest priority among the set bits of mask; ties go to source 0.
    function automatic logic [SRC_W-1:0] pick(input logic [NUM_SOURCES-1:0] mask,
                                              input logic [7:0] pa,
                                              input logic [7:0] pb);
        logic [SRC_W-1:0] sel;
        sel = NO_SOURCE;
        if (mask[0] && mask[1])
            sel = (pb > pa) ? 2'd1 : 2'd0;
        else if (mask[0])
            sel = 2'd0;
        else if (mask[1])
            sel = 2'd1;
        return sel;
    endfunction

endpackage

// ===== hdl/psched_cfg.sv =====
module psched_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psched_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psched_pkg::CFG_DATA_W-1:0]  cfg_data,
    output psched_pkg::cfg_t                   cfg
);
    import psched_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PRIORITY_A: cfg_next.priority_a = cfg_data[7:0];
                CFG_PRIORITY_B: cfg_next.priority_b = cfg_data[7:0];
                CFG_RUN_TIME_A: cfg_next.run_time_a = cfg_data;
                CFG_RUN_TIME_B: cfg_next.run_time_b = cfg_data;
                default:        cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.priority_a <= PRIORITY_A_RST;
            cfg_reg.priority_b <= PRIORITY_B_RST;
            cfg_reg.run_time_a <= RUN_TIME_A_RST;
            cfg_reg.run_time_b <= RUN_TIME_B_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/psched_core.sv =====
module psched_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  logic [psched_pkg::NUM_SOURCES-1:0] req,
    input  psched_pkg::cfg_t                   cfg,
    output psched_pkg::result_t                result
);
    import psched_pkg::*;

    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [SRC_W-1:0]       active_reg, active_next;
    logic [NUM_SOURCES-1:0] pending_reg, pending_next;
    logic [TICK_W-1:0]      start_reg   [NUM_SOURCES];
    logic [TICK_W-1:0]      start_next  [NUM_SOURCES];
    logic [TICK_W-1:0]      narr_reg    [NUM_SOURCES];
    logic [TICK_W-1:0]      narr_next   [NUM_SOURCES];
    logic [TICK_W-1:0]      carr_reg    [NUM_SOURCES];
    logic [TICK_W-1:0]      carr_next   [NUM_SOURCES];
    logic [CNT_W-1:0]       miss_reg    [NUM_SOURCES];
    logic [CNT_W-1:0]       miss_next   [NUM_SOURCES];
    logic [CNT_W-1:0]       maxlat_reg  [NUM_SOURCES];
    logic [CNT_W-1:0]       maxlat_next [NUM_SOURCES];

    logic                   act_valid;
    logic                   act_sel;
    logic [NUM_SOURCES-1:0] arrivals;
    logic [SRC_W-1:0]       best;
    logic [SRC_W-1:0]       best_idle;
    logic [15:0]            handler_ticks;
    logic [TICK_W-1:0]      elapsed;
    logic [TICK_W-1:0]      lat_full;
    logic [CNT_W-1:0]       lat;
    logic                   done;

    assign act_valid     = (active_reg != NO_SOURCE);
    assign act_sel       = active_reg[0];
    assign arrivals      = req & ~pending_reg;
    assign best          = pick(pending_reg | req, cfg.priority_a, cfg.priority_b);
    assign best_idle     = pick(req, cfg.priority_a, cfg.priority_b);
    assign handler_ticks = act_sel ? cfg.run_time_b : cfg.run_time_a;
    assign elapsed       = tick_reg - (act_sel ? start_reg[1] : start_reg[0]);
    assign lat_full      = tick_reg - (act_sel ? carr_reg[1] : carr_reg[0]);
    assign lat           = (|lat_full[TICK_W-1:CNT_W]) ? SAT16 : lat_full[CNT_W-1:0];
    assign done          = act_valid && ({{(TICK_W-16){1'b0}}, handler_ticks} <= elapsed);

    always_comb
    begin
        tick_next    = tick_reg + 32'd1;
        active_next  = active_reg;
        pending_next = pending_reg;
        start_next   = start_reg;
        narr_next    = narr_reg;
        carr_next    = carr_reg;
        maxlat_next  = maxlat_reg;
        result.finished_valid  = 1'b0;
        result.finished_source = 1'b0;
        result.finish_latency  = '0;

        for (int k = 0; k < NUM_SOURCES; k++)
        begin
            miss_next[k] = miss_reg[k];
            if (pending_reg[k] && req[k] && (miss_reg[k] != SAT16))
                miss_next[k] = miss_reg[k] + 16'd1;
        end

        if (act_valid)
        begin
            // Every new requester queues, the running source included.
            for (int k = 0; k < NUM_SOURCES; k++)
            begin
                if (arrivals[k])
                begin
                    pending_next[k] = 1'b1;
                    narr_next[k]    = tick_reg;
                end
            end
            if (done)
            begin
                result.finished_valid  = 1'b1;
                result.finished_source = act_sel;
                result.finish_latency  = lat;
                active_next = NO_SOURCE;
                for (int k = 0; k < NUM_SOURCES; k++)
                begin
                    if ((act_sel == k[0]) && (lat > maxlat_reg[k]))
                        maxlat_next[k] = lat;
                    if (best == SRC_W'(k))
                    begin
                        active_next     = best;
                        start_next[k]   = tick_reg;
                        pending_next[k] = 1'b0;
                        carr_next[k]    = narr_next[k];
                    end
                end
            end
        end
        else if (best_idle != NO_SOURCE)
        begin
            active_next = best_idle;
            for (int k = 0; k < NUM_SOURCES; k++)
            begin
                if (best_idle == SRC_W'(k))
                begin
                    start_next[k] = tick_reg;
                    carr_next[k]  = tick_reg;
                end
                else if (arrivals[k])
                begin
                    pending_next[k] = 1'b1;
                    narr_next[k]    = tick_reg;
                end
            end
        end

        result.active_source  = active_next;
        result.pending_bits   = pending_next;
        result.missed_count_a = miss_next[0];
        result.missed_count_b = miss_next[1];
        result.max_latency_a  = maxlat_next[0];
        result.max_latency_b  = maxlat_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            active_reg  <= NO_SOURCE;
            pending_reg <= '0;
            for (int k = 0; k < NUM_SOURCES; k++)
            begin
                start_reg[k]  <= '0;
                narr_reg[k]   <= '0;
                carr_reg[k]   <= '0;
                miss_reg[k]   <= '0;
                maxlat_reg[k] <= '0;
            end
        end
        else if (fire)
        begin
            tick_reg    <= tick_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
            start_reg   <= start_next;
            narr_reg    <= narr_next;
            carr_reg    <= carr_next;
            miss_reg    <= miss_next;
            maxlat_reg  <= maxlat_next;
        end
    end

endmodule

// ===== hdl/priority_interrupt_scheduler_top.sv =====
// Path: an accepted item goes through the input register, then the result register.
// Throughput: one item per clock; the input register and the result register each
//   hold one item, and the scheduler step between them is combinational, so the
//   block accepts an item every cycle while out_ready stays high.
// Reset (rst_n, asynchronous, active low): no handler active, nothing pending, tick,
//   counters and latencies zero, configuration registers at their default values.
module priority_interrupt_scheduler_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psched_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psched_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input channel: one item is one tick
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [psched_pkg::NUM_SOURCES-1:0] request_bits,
    // Result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [psched_pkg::SRC_W-1:0]       active_source,
    output logic                               finished_valid,
    output logic                               finished_source,
    output logic [psched_pkg::CNT_W-1:0]       finish_latency,
    output logic [psched_pkg::NUM_SOURCES-1:0] pending_bits,
    output logic [psched_pkg::CNT_W-1:0]       missed_count_a,
    output logic [psched_pkg::CNT_W-1:0]       missed_count_b,
    output logic [psched_pkg::CNT_W-1:0]       max_latency_a,
    output logic [psched_pkg::CNT_W-1:0]       max_latency_b
);
    import psched_pkg::*;

    cfg_t                   cfg;
    result_t                step_result;

    // Input register: holds one tick until the scheduler can take it.
    logic                   in_valid_reg, in_valid_next;
    logic [NUM_SOURCES-1:0] in_req_reg;

    // Result register: holds one finished item until the consumer takes it.
    logic                   out_valid_reg, out_valid_next;
    result_t                res_reg;

    logic                   in_take;
    logic                   fire;

    // Advance the scheduler whenever a tick waits and the result slot is free
    // or is being emptied in this same cycle.
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_req_reg <= request_bits;
        if (fire)
            res_reg <= step_result;
    end

    psched_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Scheduler state and the single-tick update step
    psched_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .req    (in_req_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    assign out_valid       = out_valid_reg;
    assign active_source   = res_reg.active_source;
    assign finished_valid  = res_reg.finished_valid;
    assign finished_source = res_reg.finished_source;
    assign finish_latency  = res_reg.finish_latency;
    assign pending_bits    = res_reg.pending_bits;
    assign missed_count_a  = res_reg.missed_count_a;
    assign missed_count_b  = res_reg.missed_count_b;
    assign max_latency_a   = res_reg.max_latency_a;
    assign max_latency_b   = res_reg.max_latency_b;

    // A pending source always starts once the handler finishes, so an idle
    // scheduler never leaves anything queued.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (active_source == NO_SOURCE) |-> (pending_bits == '0))
        else $error("idle scheduler reports pending sources");

    // Without a finish the finish fields read as zero.
    a_no_finish_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !finished_valid |-> (finish_latency == '0) && !finished_source)
        else $error("finish fields set without a finish");

    // A finished handler's latency never exceeds its source's recorded maximum.
    a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished_valid |->
            (finished_source ? (max_latency_b >= finish_latency)
                             : (max_latency_a >= finish_latency)))
        else $error("maximum latency below reported latency");

    // A tick waiting in the input register with room downstream must advance.
    a_fire_drains: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid)
        else $error("waiting tick did not advance");

endmodule
